// File: sv/drm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_pkg
// Shared types and constants for the dark run midpoint marker.
// ----------------------------------------------------------------------------
package drm_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int CHAN_W  = 8;
    localparam int BOUND_W = 11;
    localparam int OUT_ROW_W = 10;
    localparam int OUT_COL_W = 10;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_DARK_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RUN_PIXELS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RUN_PIXELS = 2'd2;

    localparam logic [CHAN_W-1:0]  RST_DARK_THRESHOLD = 8'd20;
    localparam logic [BOUND_W-1:0] RST_MIN_RUN_PIXELS = 11'd2;
    localparam logic [BOUND_W-1:0] RST_MAX_RUN_PIXELS = 11'd16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [CHAN_W-1:0]  dark_threshold;
        logic [BOUND_W-1:0] min_run_pixels;
        logic [BOUND_W-1:0] max_run_pixels;
    } drm_cfg_t;

    // closed run waiting for the midpoint stage
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] start;
        logic [COL_W-1:0] len;
    } drm_mark_t;

endpackage

// File: sv/drm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_front
// Pixel classifier and run tracker; pushes each marked run into the queue.
// ----------------------------------------------------------------------------
module drm_front import drm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  drm_cfg_t              cfg,
    input  logic                  accept,
    input  logic [CHAN_W-1:0]     red,
    input  logic [CHAN_W-1:0]     green,
    input  logic [CHAN_W-1:0]     blue,
    input  logic                  row_last,
    input  logic                  frame_last,
    output logic                  push,
    output drm_mark_t             mark
);

    logic             in_run_reg, in_run_next;
    logic [COL_W-1:0] start_reg, start_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             dark;
    logic             row_end;
    logic [COL_W-1:0] len;
    logic             in_range;

    assign dark = (red <= cfg.dark_threshold) && (green <= cfg.dark_threshold)
               && (blue <= cfg.dark_threshold);
    assign len  = col_reg - start_reg;
    assign in_range = ({1'b0, len} >= cfg.min_run_pixels)
                   && ({1'b0, len} <= cfg.max_run_pixels);
    // last column of the line buffer closes the row on its own
    assign row_end = row_last || frame_last || (col_reg == COL_W'(MAX_COLUMNS - 1));

    assign push = accept && in_run_reg && !dark && in_range;
    assign mark = '{row: row_reg, start: start_reg, len: len};

    always_comb begin
        in_run_next = in_run_reg;
        start_next  = start_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (accept) begin
            if (!in_run_reg && dark) begin
                in_run_next = 1'b1;
                start_next  = col_reg;
            end else if (in_run_reg && !dark) begin
                in_run_next = 1'b0;
            end
            if (row_end) begin
                in_run_next = 1'b0;
                start_next  = '0;
                col_next    = '0;
                if (frame_last || (row_reg == ROW_W'(MAX_ROWS - 1))) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_run_reg <= 1'b0;
            start_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            in_run_reg <= in_run_next;
            start_reg  <= start_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

`ifndef SYNTHESIS
    a_row_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (row_last || frame_last)) |=> (!in_run_reg && col_reg == '0))
        else $error("row end did not clear run state");

    a_col_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !row_end) |=> (col_reg == $past(col_reg) + 1'b1))
        else $error("column count did not advance");
`endif

endmodule

// File: sv/drm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_fifo
// Short queue of closed runs between the tracker and the midpoint stage.
// ----------------------------------------------------------------------------
module drm_fifo import drm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  drm_mark_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output drm_mark_t pop_data
);

    drm_mark_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");
`endif

endmodule

// File: sv/drm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_back
// Midpoint stage and output register of the marker stream.
// ----------------------------------------------------------------------------
module drm_back import drm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        not_empty,
    input  drm_mark_t   pop_data,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    logic                 valid_reg, valid_next;
    logic [OUT_ROW_W-1:0] row_reg;
    logic [OUT_COL_W-1:0] col_reg;
    logic [BOUND_W-1:0]   len_reg;
    logic [COL_W-1:0]     mid;

    assign pop = not_empty && (!valid_reg || m_tready);
    assign mid = pop_data.start + (pop_data.len >> 1);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            row_reg <= OUT_ROW_W'(pop_data.row);
            col_reg <= OUT_COL_W'(mid);
            len_reg <= BOUND_W'(pop_data.len);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, len_reg, col_reg, row_reg};

endmodule

// File: sv/dark_run_midpoint_marker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dark_run_midpoint_marker
// Marks the midpoint of each closed dark run of pixels within a row whose length lies in the bounds.
// ----------------------------------------------------------------------------
// path: a closed run is written into the queue, then its marker is registered in the output register
// throughput: one pixel per cycle while the queue is not full; the tracker acts on each
//   pixel as it is taken and a four-entry queue absorbs markers held back by m_tready
// reset: synchronous active-low aresetn empties the queue, clears the row and
//   column counters and loads the register defaults (20, 2, 16)
module dark_run_midpoint_marker import drm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // red, green, blue
    input  logic                   s_tlast,   // row_last
    input  logic                   s_tuser,   // frame_last
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // mark_row, mark_column, run_pixels
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    drm_cfg_t  cfg_reg, cfg_next;
    logic      accept;
    logic      push;
    drm_mark_t push_data;
    logic      full;
    logic      pop;
    logic      not_empty;
    drm_mark_t pop_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DARK_THRESHOLD: cfg_next.dark_threshold = cfg_data[CHAN_W-1:0];
                CFG_MIN_RUN_PIXELS: cfg_next.min_run_pixels = cfg_data[BOUND_W-1:0];
                CFG_MAX_RUN_PIXELS: cfg_next.max_run_pixels = cfg_data[BOUND_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{dark_threshold: RST_DARK_THRESHOLD,
                         min_run_pixels: RST_MIN_RUN_PIXELS,
                         max_run_pixels: RST_MAX_RUN_PIXELS};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    drm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .accept     (accept),
        .red        (s_tdata[7:0]),
        .green      (s_tdata[15:8]),
        .blue       (s_tdata[23:16]),
        .row_last   (s_tlast),
        .frame_last (s_tuser),
        .push       (push),
        .mark       (push_data)
    );

    drm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_data)
    );

    drm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .not_empty (not_empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dark run midpoint marker. A table of pixels
// with hand-worked markers runs first, then random raster rows follow under
// several register settings.
// A local run tracker predicts the markers where the table types none in, and
// each word taken from the master side is compared in order against the expected markers.
// ----------------------------------------------------------------------------
module tb_top;
    import drm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_PIXELS = 130;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              row_last;
        logic              frame_last;
    } pixel_t;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] column;
        logic [BOUND_W-1:0]   run_pixels;
    } marker_t;

    typedef enum logic [1:0] {
        STEP_PIXEL,    // marker taken from the run tracker
        STEP_NO_MARK,  // no marker, typed in
        STEP_MARK,     // marker typed in
        STEP_CONFIG    // register write; the three values sit in the mark fields
    } step_kind_t;

    typedef enum logic [1:0] {ROW_END, FRAME_END, ROW_FRAME_END, NO_END} end_kind_t;

    typedef struct packed {
        step_kind_t        kind;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              row_last;
        logic              frame_last;
        logic [10:0]       v0;
        logic [10:0]       v1;
        logic [10:0]       v2;
    } dir_step_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata = '0;   // red, green, blue
    logic                   s_tlast = 1'b0; // row_last
    logic                   s_tuser = 1'b0; // frame_last
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;        // mark_row, mark_column, run_pixels
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // check mode travels with each pixel word
    step_kind_t word_kind = STEP_PIXEL;
    marker_t    word_mark = '0;

    dark_run_midpoint_marker uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // run tracker state and its copy of the registers
    logic [CHAN_W-1:0]  thr_q = RST_DARK_THRESHOLD;
    logic [BOUND_W-1:0] min_q = RST_MIN_RUN_PIXELS;
    logic [BOUND_W-1:0] max_q = RST_MAX_RUN_PIXELS;
    logic               in_run = 1'b0;
    logic [COL_W-1:0]   run_start = '0;
    logic [COL_W-1:0]   col_cnt = '0;
    logic [ROW_W-1:0]   row_cnt = '0;

    marker_t   marker_q[$];
    int        err_count = 0;
    int        cycle_count = 0;
    int        sent_pixels = 0;
    int        src_idle_pct = 18;
    int        sink_idle_pct = 81;
    int        set_thr = RST_DARK_THRESHOLD;
    int        set_min = RST_MIN_RUN_PIXELS;
    int        set_max = RST_MAX_RUN_PIXELS;
    dir_step_t dir_table [29];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic report_error(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // one pixel through the run tracker; returns 1 when a run closes inside bounds
    function automatic logic track_pixel(input pixel_t px, output marker_t mk);
        logic             dark;
        logic             hit;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] len;
        dark = px.red <= thr_q && px.green <= thr_q && px.blue <= thr_q;
        col  = col_cnt;
        hit  = 1'b0;
        mk   = '0;
        if (!in_run) begin
            if (dark) begin
                in_run    = 1'b1;
                run_start = col;
            end
        end else if (!dark) begin
            len    = col - run_start;
            in_run = 1'b0;
            if ({1'b0, len} >= min_q && {1'b0, len} <= max_q) begin
                hit           = 1'b1;
                mk.row        = row_cnt;
                mk.column     = run_start + (len >> 1);
                mk.run_pixels = {1'b0, len};
            end
        end
        // open runs are dropped at every row end, forced or flagged
        if (px.row_last || px.frame_last || col == COL_W'(MAX_COLUMNS - 1)) begin
            in_run    = 1'b0;
            run_start = '0;
            col_cnt   = '0;
            if (px.frame_last || row_cnt == ROW_W'(MAX_ROWS - 1))
                row_cnt = '0;
            else
                row_cnt = row_cnt + 1'b1;
        end else begin
            col_cnt = col + 1'b1;
        end
        return hit;
    endfunction

    always @(posedge aclk) begin
        pixel_t  px;
        marker_t mk;
        marker_t got;
        marker_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DARK_THRESHOLD: thr_q = cfg_data[CHAN_W-1:0];
                    CFG_MIN_RUN_PIXELS: min_q = cfg_data;
                    CFG_MAX_RUN_PIXELS: max_q = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                px.red        = s_tdata[7:0];
                px.green      = s_tdata[15:8];
                px.blue       = s_tdata[23:16];
                px.row_last   = s_tlast;
                px.frame_last = s_tuser;
                if (track_pixel(px, mk) && word_kind == STEP_PIXEL)
                    marker_q.push_back(mk);
                if (word_kind == STEP_MARK)
                    marker_q.push_back(word_mark);
            end
            if (m_tvalid && m_tready) begin
                got.row        = m_tdata[9:0];
                got.column     = m_tdata[19:10];
                got.run_pixels = m_tdata[30:20];
                if (marker_q.size() == 0) begin
                    report_error("unexpected marker, column", got.column, 0);
                end else begin
                    want = marker_q.pop_front();
                    if (got.row != want.row)
                        report_error("mark_row", got.row, want.row);
                    if (got.column != want.column)
                        report_error("mark_column", got.column, want.column);
                    if (got.run_pixels != want.run_pixels)
                        report_error("run_pixels", got.run_pixels, want.run_pixels);
                end
            end
        end
    end

    // called at a rising edge; returns at the edge that takes the word
    task automatic send_pixel(input pixel_t px, input step_kind_t kind, input marker_t mk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {px.blue, px.green, px.red};
        s_tlast   <= px.row_last;
        s_tuser   <= px.frame_last;
        word_kind <= kind;
        word_mark <= mk;
        do @(posedge aclk); while (!s_tready);
        sent_pixels++;
    endtask

    // stop sending and wait until every marker is out, then let the pipe go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (marker_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_config(input int thr, input int mn, input int mx);
        logic [CFG_INDEX_W-1:0] idx [3];
        int                     val [3];
        idx = '{CFG_DARK_THRESHOLD, CFG_MIN_RUN_PIXELS, CFG_MAX_RUN_PIXELS};
        val = '{thr, mn, mx};
        settle();
        set_thr = thr;
        set_min = mn;
        set_max = mx;
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= CFG_DATA_W'(val[i]);
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic pixel_t make_pixel(input bit want_dark, input bit allow_noise);
        pixel_t px;
        int     ch;
        px.red        = CHAN_W'($urandom);
        px.green      = CHAN_W'($urandom);
        px.blue       = CHAN_W'($urandom);
        px.row_last   = 1'b0;
        px.frame_last = 1'b0;
        if (allow_noise && $urandom_range(9) == 0)
            return px;
        if (want_dark) begin
            px.red   = CHAN_W'(($urandom_range(3) == 0) ? set_thr
                                                        : $urandom_range(0, set_thr));
            px.green = CHAN_W'(($urandom_range(3) == 0) ? set_thr
                                                        : $urandom_range(0, set_thr));
            px.blue  = CHAN_W'(($urandom_range(3) == 0) ? set_thr
                                                        : $urandom_range(0, set_thr));
        end else if (set_thr < 255) begin
            ch = ($urandom_range(2) == 0) ? set_thr + 1 : $urandom_range(set_thr + 1, 255);
            case ($urandom_range(2))
                0: px.red = CHAN_W'(ch);
                1: px.green = CHAN_W'(ch);
                default: px.blue = CHAN_W'(ch);
            endcase
        end
        return px;
    endfunction

    // alternating dark and bright stretches, dark ones sized around the bounds
    task automatic send_row(input int len, input end_kind_t ek);
        pixel_t px;
        bit     dark_seg;
        int     seg_left;
        int     cap;
        dark_seg = $urandom_range(1);
        seg_left = 0;
        cap = ((set_min > set_max) ? set_min : set_max) + 2;
        if (cap > 48)
            cap = ($urandom_range(15) == 0) ? 1024 : 48;
        for (int c = 0; c < len; c++) begin
            if (seg_left == 0) begin
                dark_seg = !dark_seg;
                seg_left = dark_seg ? $urandom_range(1, cap) : $urandom_range(1, 3);
            end
            seg_left--;
            px = make_pixel(dark_seg, 1'b1);
            px.row_last   = (c == len - 1) && (ek == ROW_END || ek == ROW_FRAME_END);
            px.frame_last = (c == len - 1) && (ek == FRAME_END || ek == ROW_FRAME_END);
            send_pixel(px, STEP_PIXEL, '0);
        end
    endtask

    initial begin
        dir_step_t st;
        pixel_t    px;
        marker_t   mk;
        int        base;
        int        mn;
        end_kind_t ek;

        dir_table = '{
            // row 0 under reset registers (20, 2, 16)
            '{STEP_PIXEL,   8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_NO_MARK, 8'd20,  8'd20,  8'd20,  1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_NO_MARK, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_MARK,    8'd21,  8'd0,   8'd0,   1'b0, 1'b0, 11'd0, 11'd2, 11'd2},
            '{STEP_NO_MARK, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            // one-pixel run is below the minimum
            '{STEP_NO_MARK, 8'd0,   8'd21,  8'd0,   1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_NO_MARK, 8'd0,   8'd0,   8'd21,  1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_NO_MARK, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_NO_MARK, 8'd20,  8'd0,   8'd20,  1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_NO_MARK, 8'd0,   8'd20,  8'd0,   1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            // bright last pixel of the row still closes the run
            '{STEP_MARK,    8'd128, 8'd64,  8'd32,  1'b1, 1'b0, 11'd0, 11'd8, 11'd3},
            // run open at row end is dropped
            '{STEP_NO_MARK, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_NO_MARK, 8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 11'd0, 11'd0, 11'd0},
            // frame end without row end
            '{STEP_NO_MARK, 8'd5,   8'd5,   8'd5,   1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_NO_MARK, 8'd200, 8'd0,   8'd0,   1'b0, 1'b1, 11'd0, 11'd0, 11'd0},
            '{STEP_NO_MARK, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_NO_MARK, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_MARK,    8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 11'd0, 11'd1, 11'd2},
            // lowest threshold and bounds
            '{STEP_CONFIG,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 11'd0, 11'd1, 11'd1},
            '{STEP_NO_MARK, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_MARK,    8'd1,   8'd0,   8'd0,   1'b0, 1'b0, 11'd0, 11'd0, 11'd1},
            '{STEP_PIXEL,   8'd0,   8'd0,   8'd1,   1'b1, 1'b0, 11'd0, 11'd0, 11'd0},
            // highest threshold: every pixel is dark
            '{STEP_CONFIG,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 11'd255, 11'd1024, 11'd1024},
            '{STEP_NO_MARK, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_NO_MARK, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 11'd0, 11'd0, 11'd0},
            // minimum above maximum marks nothing
            '{STEP_CONFIG,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 11'd20, 11'd2, 11'd1},
            '{STEP_NO_MARK, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_NO_MARK, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 11'd0, 11'd0, 11'd0},
            '{STEP_NO_MARK, 8'd21,  8'd21,  8'd21,  1'b1, 1'b0, 11'd0, 11'd0, 11'd0}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct  = 18;
        sink_idle_pct = 81;
        foreach (dir_table[i]) begin
            st = dir_table[i];
            if (st.kind == STEP_CONFIG) begin
                set_config(st.v0, st.v1, st.v2);
            end else begin
                px = '{st.red, st.green, st.blue, st.row_last, st.frame_last};
                mk = '{st.v0[OUT_ROW_W-1:0], st.v1[OUT_COL_W-1:0], st.v2};
                send_pixel(px, st.kind, mk);
            end
        end

        for (int p = 0; p < 6; p++) begin
            src_idle_pct  = (p < 2) ? 18 : (p < 4) ? 81 : 0;
            sink_idle_pct = (p < 2) ? 81 : (p < 4) ? 18 : 0;
            case (p)
                0: set_config($urandom_range(10, 80), $urandom_range(1, 3),
                              $urandom_range(4, 20));
                1: set_config($urandom_range(0, 255), 1, 1024);
                2: begin
                    mn = $urandom_range(5, 20);
                    set_config($urandom_range(10, 200), mn, $urandom_range(1, mn - 1));
                end
                3: begin
                    mn = $urandom_range(2, 6);
                    set_config($urandom_range(0, 255), mn, mn + $urandom_range(0, 10));
                end
                4: set_config(0, 1, 8);
                default: set_config($urandom_range(0, 255), $urandom_range(1, 8),
                                    $urandom_range(1, 30));
            endcase
            base = sent_pixels;
            while (sent_pixels - base < PHASE_PIXELS) begin
                case ($urandom_range(9))
                    0: ek = FRAME_END;
                    1: ek = ROW_FRAME_END;
                    2: ek = NO_END;
                    default: ek = ROW_END;
                endcase
                send_row($urandom_range(1, 40), ek);
            end
        end

        settle();
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
